// ----- design/mlpt_pkg.sv -----
// Shared types and constants for the MAC learning port table.
// Holds table sizes, stream field widths, controller state and command types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mlpt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int NUM_PORTS   = 8;

   localparam int MAC_W       = 48;
   localparam int PORT_W      = 3;
   localparam int FLOOD_W     = 8;
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 16;

   localparam logic [FLOOD_W-1:0] FLOOD_ALL =
      (NUM_PORTS >= FLOOD_W) ? {FLOOD_W{1'b1}} : FLOOD_W'((1 << NUM_PORTS) - 1);

   localparam logic KIND_LEARN   = 1'b0;
   localparam logic KIND_FORWARD = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } mlpt_state_type;

   typedef struct packed {
      logic load;
      logic commit;
   } mlpt_cmd_type;

endpackage
`default_nettype wire

// ----- design/mac_learning_port_table_top.sv -----
// Top level of the MAC learning port table.
// Joins the controller and the datapath to the request and response streams.
// Depends on mlpt_pkg, mlpt_ctrl and mlpt_datapath.
//
// Each request item either learns a station address on a port (tuser low) or
// looks up a destination address (tuser high). Every request item gives
// exactly one response item with the hit flag, the stored port, the flood mask
// for a forward miss, and the learned and table-full flags.
// A request item is taken into the request register in the idle state and
// compared against all table entries in parallel in the execute state; the
// result then goes to the output register. The block takes no new item until
// it is through with the last, by the controller's accept-then-execute sequence.
// The response sits in an output register, so a new request item is taken
// while an earlier response still waits. If the receiver stalls, the block
// holds the finished lookup until the output register frees and takes no new
// item meanwhile; nothing is lost.
// Reset clears all entry valid bits, the controller and the response valid
// flag; the table is ready in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
module mac_learning_port_table_top (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [mlpt_pkg::REQ_TDATA_W-1:0]    req_tdata,  // mac, port_in, zero fill
   input  wire                                 req_tuser,  // kind
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [mlpt_pkg::RSP_TDATA_W-1:0]    rsp_tdata   // hit, stored port, flood_mask,
                                                           // learned, table_full, zero fill
);
   import mlpt_pkg::*;

   mlpt_cmd_type cmd;

   mlpt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   mlpt_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_kind (req_tuser),
      .req_mac  (req_tdata[MAC_W-1:0]),
      .req_port (req_tdata[MAC_W+PORT_W-1:MAC_W]),
      .rsp_data (rsp_tdata)
   );

endmodule
`default_nettype wire

// ----- design/mlpt_ctrl.sv -----
// Controller for the MAC learning port table.
// Sequences accept, table lookup and commit, and owns the result valid flag.
// Depends on mlpt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mlpt_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output mlpt_pkg::mlpt_cmd_type cmd
);
   import mlpt_pkg::*;

   mlpt_state_type state_ff;
   mlpt_state_type state_in;
   logic           out_valid_ff;
   logic           out_valid_in;
   logic           slot_free;

   assign slot_free = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_EXEC: begin
            cmd.commit = slot_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.commit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/mlpt_datapath.sv -----
// Datapath for the MAC learning port table.
// Holds the request register, the address table with parallel compare and the result register.
// Depends on mlpt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mlpt_datapath (
   input  wire                                 clock,
   input  wire                                 reset,
   input  mlpt_pkg::mlpt_cmd_type              cmd,
   input  wire                                 req_kind,
   input  wire  [mlpt_pkg::MAC_W-1:0]          req_mac,
   input  wire  [mlpt_pkg::PORT_W-1:0]         req_port,
   output logic [mlpt_pkg::RSP_TDATA_W-1:0]    rsp_data
);
   import mlpt_pkg::*;

   logic                   kind_ff;
   logic [MAC_W-1:0]       mac_ff;
   logic [PORT_W-1:0]      port_ff;

   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [MAC_W-1:0]       addr_ff [TABLE_DEPTH];
   logic [PORT_W-1:0]      eport_ff [TABLE_DEPTH];

   logic [TABLE_DEPTH-1:0] match_vec;
   logic [TABLE_DEPTH-1:0] match_oh;
   logic [TABLE_DEPTH-1:0] free_vec;
   logic [TABLE_DEPTH-1:0] free_oh;
   logic [TABLE_DEPTH-1:0] write_vec;
   logic                   any_match;
   logic                   any_free;
   logic [PORT_W-1:0]      hit_port;
   logic [FLOOD_W-1:0]     flood;
   logic                   learned;
   logic                   table_full;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_in;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         mac_ff  <= req_mac;
         port_ff <= req_port;
      end
   end

   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         match_vec[i] = valid_ff[i] && (addr_ff[i] == mac_ff);
      end
   end

   assign free_vec  = ~valid_ff;
   assign match_oh  = match_vec & (~match_vec + {{(TABLE_DEPTH-1){1'b0}}, 1'b1});
   assign free_oh   = free_vec & (~free_vec + {{(TABLE_DEPTH-1){1'b0}}, 1'b1});
   assign any_match = |match_vec;
   assign any_free  = |free_vec;

   always_comb begin
      hit_port = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         hit_port = hit_port | (eport_ff[i] & {PORT_W{match_oh[i]}});
      end
   end

   always_comb begin
      flood = '0;
      if (kind_ff == KIND_FORWARD && !any_match) begin
         flood = FLOOD_ALL;
         if (32'(port_ff) < 32'(NUM_PORTS)) begin
            flood[port_ff] = 1'b0;
         end
      end
   end

   assign learned    = (kind_ff == KIND_LEARN) && !any_match && any_free;
   assign table_full = (kind_ff == KIND_LEARN) && !any_match && !any_free;
   assign write_vec  = (cmd.commit && learned) ? free_oh : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_ff | write_vec;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (write_vec[i]) begin
            addr_ff[i]  <= mac_ff;
            eport_ff[i] <= port_ff;
         end
      end
   end

   assign rsp_data_in = {2'b00, table_full, learned, flood, hit_port, any_match};

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for the MAC learning port table (mac_learning_port_table_top).
// Streams learn and forward items with random gaps and stalls, and checks each response.
// Depends on mlpt_pkg and mac_learning_port_table_top.
`timescale 1ns / 1ps
module testbench;
   import mlpt_pkg::*;

   localparam int RANDOM_ITEMS   = 1475;
   localparam int DRAIN_AT       = 700;
   localparam int HOLD_AT        = 400;
   localparam int HOLD_CYCLES    = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 20;

   typedef struct {
      logic              kind;
      logic [MAC_W-1:0]  mac;
      logic [PORT_W-1:0] port_in;
      bit                drain;
   } table_request_type;

   typedef struct {
      logic               hit;
      logic [PORT_W-1:0]  egress_port;
      logic [FLOOD_W-1:0] flood_mask;
      logic               learned;
      logic               table_full;
   } lookup_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   table_request_type pending_requests[$];
   lookup_result_type expected_results[$];
   logic [MAC_W-1:0] stored_macs[$];

   logic              station_valid [TABLE_DEPTH];
   logic [MAC_W-1:0]  station_mac   [TABLE_DEPTH];
   logic [PORT_W-1:0] station_port  [TABLE_DEPTH];

   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   int rsp_count = 0;
   int error_count = 0;
   int idle_cycles = 0;
   int req_wait = 0;
   int req_burst = 0;
   int rsp_wait = 0;
   int rsp_burst = 0;
   int hold_left = 0;

   mac_learning_port_table_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   function automatic int draw_gap(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         burst = $urandom_range(20, 80);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   function automatic lookup_result_type learn_or_forward(logic kind, logic [MAC_W-1:0] mac,
                                                          logic [PORT_W-1:0] port_in);
      lookup_result_type res;
      int match;
      int free_slot;
      res = '{default: '0};
      match = -1;
      free_slot = -1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (station_valid[i]) begin
            if (match < 0 && station_mac[i] == mac) match = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      if (match >= 0) begin
         res.hit = 1'b1;
         res.egress_port = station_port[match];
      end
      if (kind == KIND_LEARN) begin
         if (match < 0) begin
            if (free_slot >= 0) begin
               station_valid[free_slot] = 1'b1;
               station_mac[free_slot] = mac;
               station_port[free_slot] = port_in;
               res.learned = 1'b1;
            end else begin
               res.table_full = 1'b1;
            end
         end
      end else if (match < 0) begin
         for (int p = 0; p < FLOOD_W; p++)
            res.flood_mask[p] = (p < NUM_PORTS) && (p != int'(port_in));
      end
      return res;
   endfunction

   task automatic add_request(logic kind, logic [MAC_W-1:0] mac, logic [PORT_W-1:0] port_in,
                              bit drain = 1'b0);
      bit known;
      known = 1'b0;
      foreach (stored_macs[i])
         if (stored_macs[i] == mac) known = 1'b1;
      if (kind == KIND_LEARN && !known && stored_macs.size() < TABLE_DEPTH)
         stored_macs.insert(stored_macs.size(), mac);
      pending_requests.insert(pending_requests.size(), '{kind, mac, port_in, drain});
   endtask

   function automatic logic [MAC_W-1:0] random_mac();
      return MAC_W'({$urandom(), $urandom()});
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endtask

   // Prediction and checking; the response is checked before a new item is predicted.
   always @(posedge clock) begin
      lookup_result_type want;
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
         for (int i = 0; i < TABLE_DEPTH; i++) station_valid[i] = 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         rsp_fire <= rsp_tvalid && rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            rsp_count <= rsp_count + 1;
            if (expected_results.size() == 0) begin
               $error("Response item with no expected item: %0h", rsp_tdata);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("hit", want.hit, rsp_tdata[0]);
               check_field("egress_port", want.egress_port, rsp_tdata[3:1]);
               check_field("flood_mask", want.flood_mask, rsp_tdata[11:4]);
               check_field("learned", want.learned, rsp_tdata[12]);
               check_field("table_full", want.table_full, rsp_tdata[13]);
            end
         end
         if (req_tvalid && req_tready)
            expected_results.insert(expected_results.size(),
                                    learn_or_forward(req_tuser, req_tdata[MAC_W-1:0],
                                                     req_tdata[MAC_W+PORT_W-1:MAC_W]));
      end
   end

   always @(negedge clock) begin
      table_request_type next_request;
      logic next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         next_valid = req_tvalid && !req_fire;
         if (!next_valid) begin
            if (req_fire) req_wait = draw_gap(req_burst);
            if (req_wait > 0) begin
               req_wait--;
            end else if (pending_requests.size() > 0 &&
                         (!pending_requests[0].drain || expected_results.size() == 0)) begin
               next_request = pending_requests.pop_front();
               next_valid = 1'b1;
               req_tdata <= REQ_TDATA_W'({next_request.port_in, next_request.mac});
               req_tuser <= next_request.kind;
            end
         end
         req_tvalid <= next_valid;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_fire) begin
            rsp_wait = draw_gap(rsp_burst);
            if (rsp_count == HOLD_AT) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      logic [MAC_W-1:0] mac;
      int pick;

      add_request(KIND_FORWARD, '0, 3'd0);
      add_request(KIND_FORWARD, '1, 3'd7);
      add_request(KIND_LEARN, '0, 3'd0);
      add_request(KIND_LEARN, '1, 3'd7);
      add_request(KIND_LEARN, '0, 3'd5);
      add_request(KIND_FORWARD, '0, 3'd3);
      add_request(KIND_FORWARD, '1, 3'd7);
      add_request(KIND_FORWARD, 48'h5555_5555_5555, 3'd4);
      add_request(KIND_LEARN, 48'hAAAA_AAAA_AAAA, 3'd2);
      while (stored_macs.size() < TABLE_DEPTH)
         add_request(KIND_LEARN, random_mac(), PORT_W'(stored_macs.size()));
      add_request(KIND_LEARN, random_mac(), 3'd1);
      add_request(KIND_LEARN, '0, 3'd6);
      add_request(KIND_FORWARD, random_mac(), 3'd5);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            mac = stored_macs[$urandom_range(0, stored_macs.size() - 1)];
         end else if (pick < 70) begin
            mac = stored_macs[$urandom_range(0, stored_macs.size() - 1)];
            mac[$urandom_range(0, MAC_W - 1)] ^= 1'b1;
         end else begin
            mac = random_mac();
         end
         add_request(1'($urandom_range(0, 1)), mac, PORT_W'($urandom_range(0, 7)),
                     n == DRAIN_AT);
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_requests.size() > 0 || req_tvalid || expected_results.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

// ----- mac_learning_port_table_top.f -----
design/mlpt_pkg.sv
design/mlpt_ctrl.sv
design/mlpt_datapath.sv
design/mac_learning_port_table_top.sv
test/testbench.sv
